### rtl/suv_pkg.sv
`default_nettype none
package suv_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int DIFF_W        = COORD_WIDTH + 1;
    localparam int UV_FRAC_BITS  = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int NORM_FRAC     = 30;
    localparam int RAD_W         = 31;
    localparam int Q_W           = NORM_FRAC + 1;
    localparam int DIV_STEPS     = NORM_FRAC;
    localparam int SQRT_STEPS    = NORM_FRAC + 1;
    localparam int MAG_W         = 59;
    localparam int NORM_STAGES   = 6;
    localparam int CW            = 62;
    localparam int SQ_W          = 62;
    localparam int ANG_W         = 32;
    localparam int U_DELAY       = 5 + DIV_STEPS + SQRT_STEPS;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd3;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] THREE_QUARTER = 32'hC000_0000;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             sx;
        logic             sy;
    } norm_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     ang;
    } cordic_t;

    typedef struct packed {
        logic sgn;
        logic ge;
    } div_side_t;

    typedef struct packed {
        logic           sgn;
        logic [Q_W-1:0] q;
    } sqrt_side_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] res;
    } sqrt_t;

    // atan(2^-i) in turns scaled by 2^32
    function automatic logic [ANG_W-1:0] turn_atan(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            5'd31: a = 32'h00000000;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // a zero vector takes the add branch in every stage; this bias cancels it
    function automatic logic [ANG_W-1:0] zero_bias();
        logic [ANG_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            acc = acc - turn_atan(5'(i));
        end
        return acc;
    endfunction

    localparam logic [ANG_W-1:0] ZERO_BIAS = zero_bias();

    // signed operands with a left half-plane vector turned by half a turn
    function automatic cordic_t cordic_prep(input norm_t n);
        cordic_t              c;
        logic signed [CW-1:0] my;
        logic                 flip;
        logic                 zero;
        my    = $signed({{(CW-MAG_W){1'b0}}, n.ay});
        zero  = (n.ax | n.ay) == '0;
        flip  = n.sx && (n.ax != '0);
        c.x   = $signed({{(CW-MAG_W){1'b0}}, n.ax});
        c.y   = (n.sy ^ flip) ? -my : my;
        c.ang = zero ? ZERO_BIAS : (flip ? HALF_TURN : '0);
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/sphere_uv_mapping_top.sv
// spherical uv mapping of hit points
// input channel: in_valid/in_ready, one hit point (hit_x, hit_y, hit_z) per beat,
// signed q16.16. output channel: out_valid/out_ready, tex_u (q0.16) and
// tex_v (q1.16, 65536 = 1.0) per beat, one result for every input beat.
// config channel: cfg_valid/cfg_ready (always ready), cfg_index 0..3 selects
// center_x, center_y, center_z, sphere_radius; other indexes are ignored.
// write config only while no beat is in flight.
// one beat is accepted per cycle while the chain is not held; the chain from
// input beat to output beat is: subtract, magnitude, divider load, 30 divider
// steps, quotient select, squaring, square-root load, 31 square-root steps,
// 6 normalising shifts, cordic load, 18 cordic stages and the output register.
// the whole chain moves as one: when the output register holds an untaken
// beat and out_ready is low, every stage holds and in_ready drops; it
// rises again in the cycle the output beat is taken.
// reset clears all stage valids, centre to 0 and radius to 1.0.
`default_nettype none
module sphere_uv_mapping_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [suv_pkg::COORD_WIDTH-1:0] hit_x,
    input  wire logic signed [suv_pkg::COORD_WIDTH-1:0] hit_y,
    input  wire logic signed [suv_pkg::COORD_WIDTH-1:0] hit_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [suv_pkg::UV_FRAC_BITS-1:0]         tex_u,
    output logic [suv_pkg::UV_FRAC_BITS:0]           tex_v,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [suv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [suv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CWD = suv_pkg::COORD_WIDTH;
    localparam int DW  = suv_pkg::DIFF_W;
    localparam int UVF = suv_pkg::UV_FRAC_BITS;

    logic en;

    logic [CWD-1:0]            center_x_reg, center_y_reg, center_z_reg;
    logic [suv_pkg::RAD_W-1:0] radius_reg;
    logic [suv_pkg::RAD_W-1:0] radius_eff;

    logic                 s0_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [DW-1:0]        abs_dx, abs_dz;

    logic          s1_valid_reg;
    logic [DW-1:0] ady_reg;
    logic          s1_sgn_reg;

    logic                         div_valid [0:suv_pkg::DIV_STEPS];
    logic [suv_pkg::RAD_W-1:0]     div_rem   [0:suv_pkg::DIV_STEPS];
    logic [suv_pkg::DIV_STEPS-1:0] div_quo   [0:suv_pkg::DIV_STEPS];
    suv_pkg::div_side_t            div_side  [0:suv_pkg::DIV_STEPS];

    logic                     q_valid_reg, sq_valid_reg, n_valid_reg;
    suv_pkg::sqrt_side_t      q_side_reg, sq_side_reg;
    logic [suv_pkg::SQ_W-1:0] sq_reg;

    logic                 sqrt_valid [0:suv_pkg::SQRT_STEPS];
    suv_pkg::sqrt_t       sqrt_data  [0:suv_pkg::SQRT_STEPS];
    suv_pkg::sqrt_side_t  sqrt_side  [0:suv_pkg::SQRT_STEPS];

    logic             az_nv [0:suv_pkg::NORM_STAGES];
    suv_pkg::norm_t   az_nd [0:suv_pkg::NORM_STAGES];
    logic             ac_nv [0:suv_pkg::NORM_STAGES];
    suv_pkg::norm_t   ac_nd [0:suv_pkg::NORM_STAGES];

    logic             az_cv [0:suv_pkg::CORDIC_STAGES];
    suv_pkg::cordic_t az_cd [0:suv_pkg::CORDIC_STAGES];
    logic             ac_cv [0:suv_pkg::CORDIC_STAGES];
    suv_pkg::cordic_t ac_cd [0:suv_pkg::CORDIC_STAGES];

    logic [UVF-1:0] u_dly_reg [0:suv_pkg::U_DELAY-1];
    logic [suv_pkg::ANG_W-1:0] u_sum;
    logic [suv_pkg::ANG_W-1:0] av;
    logic [suv_pkg::ANG_W:0]   v_sum;
    logic [UVF:0]              v_val;

    logic           out_valid_reg;
    logic [UVF-1:0] tex_u_reg;
    logic [UVF:0]   tex_v_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= suv_pkg::RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                suv_pkg::REG_CENTER_X: center_x_reg <= cfg_data[CWD-1:0];
                suv_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[CWD-1:0];
                suv_pkg::REG_CENTER_Z: center_z_reg <= cfg_data[CWD-1:0];
                suv_pkg::REG_RADIUS:   radius_reg   <= cfg_data[suv_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign radius_eff = (radius_reg == '0) ? suv_pkg::RAD_W'(1) : radius_reg;

    // stage valid flags along the chain, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            div_valid[0] <= 1'b0;
            q_valid_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
            n_valid_reg  <= 1'b0;
            az_cv[0]     <= 1'b0;
            ac_cv[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            div_valid[0]  <= s1_valid_reg;
            q_valid_reg   <= div_valid[suv_pkg::DIV_STEPS];
            sq_valid_reg  <= q_valid_reg;
            n_valid_reg   <= sq_valid_reg;
            az_cv[0]      <= az_nv[suv_pkg::NORM_STAGES];
            ac_cv[0]      <= ac_nv[suv_pkg::NORM_STAGES];
            out_valid_reg <= ac_cv[suv_pkg::CORDIC_STAGES];
        end
    end

    assign abs_dx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign abs_dz = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= $signed({hit_x[CWD-1], hit_x}) -
                      $signed({center_x_reg[CWD-1], center_x_reg});
            dy_reg <= $signed({hit_y[CWD-1], hit_y}) -
                      $signed({center_y_reg[CWD-1], center_y_reg});
            dz_reg <= $signed({hit_z[CWD-1], hit_z}) -
                      $signed({center_z_reg[CWD-1], center_z_reg});

            ady_reg    <= dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
            s1_sgn_reg <= dy_reg[DW-1];

            // off the sphere: height clamps to one
            div_side[0].sgn <= s1_sgn_reg;
            div_side[0].ge  <= ady_reg >= DW'(radius_eff);
            div_rem[0]      <= (ady_reg >= DW'(radius_eff)) ? '0
                                                            : ady_reg[suv_pkg::RAD_W-1:0];
            div_quo[0]      <= '0;

            q_side_reg.sgn <= div_side[suv_pkg::DIV_STEPS].sgn;
            q_side_reg.q   <= div_side[suv_pkg::DIV_STEPS].ge
                              ? suv_pkg::Q_W'(1) << suv_pkg::NORM_FRAC
                              : {1'b0, div_quo[suv_pkg::DIV_STEPS]};

            sq_reg      <= suv_pkg::SQ_W'(q_side_reg.q) * suv_pkg::SQ_W'(q_side_reg.q);
            sq_side_reg <= q_side_reg;

            sqrt_data[0].n   <= (suv_pkg::SQ_W'(1) << (2 * suv_pkg::NORM_FRAC)) - sq_reg;
            sqrt_data[0].res <= '0;
            sqrt_side[0]     <= sq_side_reg;

            az_cd[0] <= suv_pkg::cordic_prep(az_nd[suv_pkg::NORM_STAGES]);
            ac_cd[0] <= suv_pkg::cordic_prep(ac_nd[suv_pkg::NORM_STAGES]);

            u_dly_reg[0] <= u_sum[suv_pkg::ANG_W-1 -: UVF];
            for (int k = 1; k < suv_pkg::U_DELAY; k++)
            begin
                u_dly_reg[k] <= u_dly_reg[k-1];
            end

            tex_u_reg <= u_dly_reg[suv_pkg::U_DELAY-1];
            tex_v_reg <= v_val;
        end
    end

    assign sqrt_valid[0] = n_valid_reg;

    // divider chain: height as a fraction of the radius
    for (genvar g = 0; g < suv_pkg::DIV_STEPS; g++)
    begin : g_div
        suv_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[g]),
            .in_rem    (div_rem[g]),
            .in_quo    (div_quo[g]),
            .in_side   (div_side[g]),
            .divisor   (radius_eff),
            .out_valid (div_valid[g+1]),
            .out_rem   (div_rem[g+1]),
            .out_quo   (div_quo[g+1]),
            .out_side  (div_side[g+1])
        );
    end

    // square-root chain: sqrt(1 - ny^2)
    for (genvar g = 0; g < suv_pkg::SQRT_STEPS; g++)
    begin : g_sqrt
        suv_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(g)),
            .in_valid  (sqrt_valid[g]),
            .in_data   (sqrt_data[g]),
            .in_side   (sqrt_side[g]),
            .out_valid (sqrt_valid[g+1]),
            .out_data  (sqrt_data[g+1]),
            .out_side  (sqrt_side[g+1])
        );
    end

    assign az_nv[0]    = s0_valid_reg;
    assign az_nd[0].ax = suv_pkg::MAG_W'(abs_dx);
    assign az_nd[0].ay = suv_pkg::MAG_W'(abs_dz);
    assign az_nd[0].sx = dx_reg[DW-1];
    assign az_nd[0].sy = dz_reg[DW-1];

    assign ac_nv[0]    = sqrt_valid[suv_pkg::SQRT_STEPS];
    assign ac_nd[0].ax = suv_pkg::MAG_W'(sqrt_side[suv_pkg::SQRT_STEPS].q);
    assign ac_nd[0].ay = sqrt_data[suv_pkg::SQRT_STEPS].res[suv_pkg::MAG_W-1:0];
    assign ac_nd[0].sx = sqrt_side[suv_pkg::SQRT_STEPS].sgn;
    assign ac_nd[0].sy = 1'b0;

    // normalising shifts, 32 down to 1
    for (genvar g = 0; g < suv_pkg::NORM_STAGES; g++)
    begin : g_norm
        suv_norm_cell u_az (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (3'(suv_pkg::NORM_STAGES - 1 - g)),
            .in_valid  (az_nv[g]),
            .in_data   (az_nd[g]),
            .out_valid (az_nv[g+1]),
            .out_data  (az_nd[g+1])
        );
        suv_norm_cell u_ac (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (3'(suv_pkg::NORM_STAGES - 1 - g)),
            .in_valid  (ac_nv[g]),
            .in_data   (ac_nd[g]),
            .out_valid (ac_nv[g+1]),
            .out_data  (ac_nd[g+1])
        );
    end

    for (genvar g = 0; g < suv_pkg::CORDIC_STAGES; g++)
    begin : g_cordic
        suv_cordic_cell u_az (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(g)),
            .in_valid  (az_cv[g]),
            .in_data   (az_cd[g]),
            .out_valid (az_cv[g+1]),
            .out_data  (az_cd[g+1])
        );
        suv_cordic_cell u_ac (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(g)),
            .in_valid  (ac_cv[g]),
            .in_data   (ac_cd[g]),
            .out_valid (ac_cv[g+1]),
            .out_data  (ac_cd[g+1])
        );
    end

    // u rounds half up and wraps a full turn to zero
    assign u_sum = az_cd[suv_pkg::CORDIC_STAGES].ang +
                   (suv_pkg::ANG_W'(1) << (suv_pkg::ANG_W - 1 - UVF));

    // v: clamp overshoot around zero and half a turn, then round and saturate
    always_comb
    begin
        av = ac_cd[suv_pkg::CORDIC_STAGES].ang;
        if (av >= suv_pkg::THREE_QUARTER)
        begin
            av = '0;
        end
        else if (av > suv_pkg::HALF_TURN)
        begin
            av = suv_pkg::HALF_TURN;
        end
        v_sum = {1'b0, av} + ((suv_pkg::ANG_W + 1)'(1) << (suv_pkg::ANG_W - 2 - UVF));
        v_val = (UVF + 1)'(v_sum >> (suv_pkg::ANG_W - 1 - UVF));
        if (v_val > ((UVF + 1)'(1) << UVF))
        begin
            v_val = (UVF + 1)'(1) << UVF;
        end
    end

endmodule
`default_nettype wire

### rtl/suv_div_cell.sv
`default_nettype none
module suv_div_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [suv_pkg::RAD_W-1:0]     in_rem,
    input  wire logic [suv_pkg::DIV_STEPS-1:0] in_quo,
    input  wire suv_pkg::div_side_t            in_side,
    input  wire logic [suv_pkg::RAD_W-1:0]     divisor,
    output logic                               out_valid,
    output logic [suv_pkg::RAD_W-1:0]          out_rem,
    output logic [suv_pkg::DIV_STEPS-1:0]      out_quo,
    output suv_pkg::div_side_t                 out_side
);

    logic [suv_pkg::RAD_W:0] trial;
    logic [suv_pkg::RAD_W:0] diff;
    logic                    fits;

    always_comb
    begin
        trial = {in_rem, 1'b0};
        diff  = trial - {1'b0, divisor};
        fits  = trial >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem  <= fits ? diff[suv_pkg::RAD_W-1:0] : trial[suv_pkg::RAD_W-1:0];
            out_quo  <= {in_quo[suv_pkg::DIV_STEPS-2:0], fits};
            out_side <= in_side;
        end
    end

endmodule
`default_nettype wire

### rtl/suv_sqrt_cell.sv
`default_nettype none
module suv_sqrt_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [4:0]          step,
    input  wire logic                in_valid,
    input  wire suv_pkg::sqrt_t      in_data,
    input  wire suv_pkg::sqrt_side_t in_side,
    output logic                     out_valid,
    output suv_pkg::sqrt_t           out_data,
    output suv_pkg::sqrt_side_t      out_side
);

    logic [5:0]                 sh;
    logic [suv_pkg::SQ_W-1:0]   one_bit;
    logic [suv_pkg::SQ_W-1:0]   trial;
    suv_pkg::sqrt_t             nxt;

    always_comb
    begin
        sh      = 6'(2 * suv_pkg::NORM_FRAC) - {step, 1'b0};
        one_bit = suv_pkg::SQ_W'(1) << sh;
        trial   = in_data.res + one_bit;
        if (in_data.n >= trial)
        begin
            nxt.n   = in_data.n - trial;
            nxt.res = (in_data.res >> 1) + one_bit;
        end
        else
        begin
            nxt.n   = in_data.n;
            nxt.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data <= nxt;
            out_side <= in_side;
        end
    end

endmodule
`default_nettype wire

### rtl/suv_norm_cell.sv
`default_nettype none
module suv_norm_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [2:0]     step,
    input  wire logic           in_valid,
    input  wire suv_pkg::norm_t in_data,
    output logic                out_valid,
    output suv_pkg::norm_t      out_data
);

    logic [6:0]     amt;
    logic [6:0]     lim;
    logic           room;
    suv_pkg::norm_t nxt;

    // shift both magnitudes by 2^step while the larger one stays in range
    always_comb
    begin
        amt  = 7'd1 << step;
        lim  = 7'(suv_pkg::MAG_W) - amt;
        room = ((in_data.ax | in_data.ay) >> lim) == '0;
        nxt  = in_data;
        if (room)
        begin
            nxt.ax = in_data.ax << amt;
            nxt.ay = in_data.ay << amt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data <= nxt;
        end
    end

endmodule
`default_nettype wire

### rtl/suv_cordic_cell.sv
`default_nettype none
module suv_cordic_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [4:0]       step,
    input  wire logic             in_valid,
    input  wire suv_pkg::cordic_t in_data,
    output logic                  out_valid,
    output suv_pkg::cordic_t      out_data
);

    logic signed [suv_pkg::CW-1:0] sx;
    logic signed [suv_pkg::CW-1:0] sy;
    suv_pkg::cordic_t              nxt;

    always_comb
    begin
        sx = in_data.x >>> step;
        sy = in_data.y >>> step;
        if (!in_data.y[suv_pkg::CW-1])
        begin
            nxt.x   = in_data.x + sy;
            nxt.y   = in_data.y - sx;
            nxt.ang = in_data.ang + suv_pkg::turn_atan(step);
        end
        else
        begin
            nxt.x   = in_data.x - sy;
            nxt.y   = in_data.y + sx;
            nxt.ang = in_data.ang - suv_pkg::turn_atan(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data <= nxt;
        end
    end

endmodule
`default_nettype wire
